/* rtl/sbh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbh_pkg: shared types, constants and functions of the SHA-256 block hasher
// Holds the channel payloads, the sequencer control bundle, the round
// constants, the initial hash value and the sigma functions.
// ----------------------------------------------------------------------------
package sbh_pkg;

	typedef logic [31:0] word_t;
	typedef logic [7:0][31:0] hash_t;

	typedef struct packed {
		logic [31:0] message_word;
		logic        message_end;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  digest_index;
		logic        digest_last;
	} digest_t;

	// Control bundle from the sequencer to the datapath.
	typedef struct packed {
		logic       ready;
		logic       word_shift;
		logic       vars_load;
		logic       round_step;
		logic       chain_add;
		logic       chain_reset;
		logic       out_valid;
		logic [5:0] round_idx;
		logic [2:0] digest_idx;
	} ctrl_t;

	localparam logic [2:0] DIGEST_LAST_IDX = 3'd7;

	localparam word_t ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Word 0 sits in the low slot.
	localparam hash_t H_INIT = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic word_t bsig0(input word_t v);
		return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
	endfunction

	function automatic word_t bsig1(input word_t v);
		return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
	endfunction

	function automatic word_t ssig0(input word_t v);
		return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
	endfunction

	function automatic word_t ssig1(input word_t v);
		return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'b0, v[31:10]};
	endfunction

endpackage

/* rtl/sha256_block_hasher_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_block_hasher_top: SHA-256 compression over a padded word stream
// Takes sixteen 32-bit words per 512-bit block, runs the 64 rounds on one
// shared round unit and, on a block carrying the end mark, hands out the
// eight digest words before returning to the initial hash value.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Payload     Handshake
//   msg       into        msg_t       msg_valid / msg_stall
//   dig       out of      digest_t    dig_valid / dig_stall
//
// Message words are taken while msg_stall is low. The sixteenth word of a
// block starts the 64 rounds on the single round unit, then the ADD state
// folds the working variables into the chaining hash. A final block adds
// eight digest transfers, one per cycle unless dig_stall holds them.
// msg_stall is high from the sixteenth word until the block, and its digest
// if any, is finished.
// Reset loads the initial hash value and clears the sequencer.
//
module sha256_block_hasher_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              msg_valid,
	output logic              msg_stall,
	input  sbh_pkg::msg_t     msg,
	output logic              dig_valid,
	input  logic              dig_stall,
	output sbh_pkg::digest_t  digest
);
	import sbh_pkg::*;

	ctrl_t ctrl;
	hash_t chain_q;
	hash_t vars;
	word_t w_cur;

	// The sequencer decides when words shift in, when rounds run and when the
	// digest is handed out.
	sbh_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.msg_valid   (msg_valid),
		.message_end (msg.message_end),
		.dig_stall   (dig_stall),
		.ctrl        (ctrl)
	);

	// Schedule window: loads the block, then expands it in place round by round.
	sbh_sched u_sched (
		.clk          (clk),
		.ctrl         (ctrl),
		.message_word (msg.message_word),
		.w_cur        (w_cur)
	);

	// The one round unit, reused for all 64 rounds of a block.
	sbh_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.chain  (chain_q),
		.w_cur  (w_cur),
		.vars   (vars)
	);

	// The chaining hash takes the round result after the last round, and goes
	// back to the initial value once the final digest word has been transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= H_INIT;
		end else if (ctrl.chain_reset) begin
			chain_q <= H_INIT;
		end else if (ctrl.chain_add) begin
			for (int j = 0; j < 8; j++) begin
				chain_q[j] <= chain_q[j] + vars[j];
			end
		end
	end

	// The digest words are read straight from the chain registers, which do not
	// change while a transfer is stalled.
	assign msg_stall           = !ctrl.ready;
	assign dig_valid           = ctrl.out_valid;
	assign digest.digest_word  = chain_q[ctrl.digest_idx];
	assign digest.digest_index = ctrl.digest_idx;
	assign digest.digest_last  = (ctrl.digest_idx == DIGEST_LAST_IDX);

endmodule

/* rtl/sbh_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbh_seq: block sequencer
// Counts message words, steps the shared round unit through 64 rounds,
// folds the result into the chain and walks the eight digest transfers.
// ----------------------------------------------------------------------------
module sbh_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          msg_valid,
	input  logic          message_end,
	input  logic          dig_stall,
	output sbh_pkg::ctrl_t ctrl
);
	import sbh_pkg::*;

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_ADD   = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0] state_q;
	logic [3:0] pos_q;
	logic [5:0] rnd_q;
	logic [2:0] dig_q;
	logic       end_q;
	logic       accept;
	logic       dig_done;

	assign accept   = (state_q == ST_LOAD) && msg_valid;
	assign dig_done = (state_q == ST_OUT) && !dig_stall;

	always_comb begin
		ctrl             = '0;
		ctrl.ready       = (state_q == ST_LOAD);
		ctrl.word_shift  = accept;
		ctrl.vars_load   = accept && (pos_q == 4'd15);
		ctrl.round_step  = (state_q == ST_ROUND);
		ctrl.chain_add   = (state_q == ST_ADD);
		ctrl.out_valid   = (state_q == ST_OUT);
		ctrl.chain_reset = dig_done && (dig_q == DIGEST_LAST_IDX);
		ctrl.round_idx   = rnd_q;
		ctrl.digest_idx  = dig_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			pos_q   <= '0;
			rnd_q   <= '0;
			dig_q   <= '0;
			end_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						pos_q <= pos_q + 4'd1;
						if (message_end) begin
							end_q <= 1'b1;
						end
						if (pos_q == 4'd15) begin
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					dig_q   <= '0;
					state_q <= end_q ? ST_OUT : ST_LOAD;
				end
				ST_OUT: begin
					if (dig_done) begin
						dig_q <= dig_q + 3'd1;
						if (dig_q == DIGEST_LAST_IDX) begin
							end_q   <= 1'b0;
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

/* rtl/sbh_sched.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbh_sched: message schedule window
// Sixteen-word shift line. Message words shift in during loading; each
// round shifts the next expanded word in and presents the current one.
// ----------------------------------------------------------------------------
module sbh_sched (
	input  logic           clk,
	input  sbh_pkg::ctrl_t ctrl,
	input  sbh_pkg::word_t message_word,
	output sbh_pkg::word_t w_cur
);
	import sbh_pkg::*;

	word_t win_q [16];
	word_t w_next;

	// Slot j holds W[r+j] during round r.
	assign w_next = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
	assign w_cur  = win_q[0];

	always_ff @(posedge clk) begin
		if (ctrl.word_shift || ctrl.round_step) begin
			for (int j = 0; j < 15; j++) begin
				win_q[j] <= win_q[j + 1];
			end
			win_q[15] <= ctrl.word_shift ? message_word : w_next;
		end
	end

endmodule

/* rtl/sbh_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbh_round: shared compression round unit
// Holds the working variables a to h and applies one SHA-256 round per
// step, loading them from the chaining hash at the start of a block.
// ----------------------------------------------------------------------------
module sbh_round (
	input  logic           clk,
	input  logic           arst_n,
	input  sbh_pkg::ctrl_t ctrl,
	input  sbh_pkg::hash_t chain,
	input  sbh_pkg::word_t w_cur,
	output sbh_pkg::hash_t vars
);
	import sbh_pkg::*;

	hash_t v_q;
	word_t t1;
	word_t t2;
	word_t ch;
	word_t maj;

	assign ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1   = v_q[7] + bsig1(v_q[4]) + ch + ROUND_K[ctrl.round_idx] + w_cur;
	assign t2   = bsig0(v_q[0]) + maj;
	assign vars = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (ctrl.vars_load) begin
			v_q <= chain;
		end else if (ctrl.round_step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

/* rtl/sbh_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbh_checker: port-level checks for the SHA-256 block hasher
// Watches the digest sequence and its relation to the message channel.
// ----------------------------------------------------------------------------
module sbh_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             msg_stall,
	input  logic             dig_valid,
	input  logic             dig_stall,
	input  sbh_pkg::digest_t digest
);
	import sbh_pkg::*;

	// No message word is taken while a digest is being handed out.
	a_no_msg_during_digest: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> msg_stall)
		else $error("message channel open while digest pending");

	// A digest always starts at word zero.
	a_digest_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dig_valid) |-> (digest.digest_index == 3'd0))
		else $error("digest does not start at index zero");

	// After a transfer that is not the last, the next word follows in order.
	a_digest_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && !dig_stall && !digest.digest_last) |=>
		(dig_valid && (digest.digest_index == 3'($past(digest.digest_index) + 3'd1))))
		else $error("digest words out of order");

	// The last flag marks exactly the eighth word.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> (digest.digest_last == (digest.digest_index == DIGEST_LAST_IDX)))
		else $error("digest_last does not match digest_index");

	// A stalled digest word holds.
	a_dig_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && dig_stall) |=> (dig_valid && $stable(digest)))
		else $error("stalled digest word changed");

endmodule

bind sha256_block_hasher_top sbh_checker u_sbh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.msg_stall (msg_stall),
	.dig_valid (dig_valid),
	.dig_stall (dig_stall),
	.digest    (digest)
);
